@@ design/lzwd_pkg.sv @@
package lzwd_pkg;

   localparam int HIST_DEPTH = 128;
   localparam int HIST_AW    = $clog2(HIST_DEPTH);
   localparam int BYTE_W     = 8;
   localparam int DATA_W     = 32;
   localparam int OCNT_W     = 3;
   localparam int TOTAL_W    = 24;

   // header bytes below this start a literal run, the rest are back-offsets
   localparam logic [BYTE_W-1:0] LIT_LIMIT = 8'd128;

endpackage

@@ design/lzwd_req_if.sv @@
interface lzwd_req_if;

   logic                             valid;
   logic                             ready;
   logic [lzwd_pkg::BYTE_W-1:0]      in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);

endinterface

@@ design/lzwd_rsp_if.sv @@
interface lzwd_rsp_if;

   logic                             valid;
   logic                             ready;
   logic [lzwd_pkg::DATA_W-1:0]      out_data;
   logic [lzwd_pkg::OCNT_W-1:0]      out_count;
   logic                             last;
   logic                             stream_end;
   logic [lzwd_pkg::TOTAL_W-1:0]     total_out;
   logic [lzwd_pkg::TOTAL_W-1:0]     total_in;

   modport source (output valid, output out_data, output out_count, output last,
                   output stream_end, output total_out, output total_in, input ready);
   modport sink   (input valid, input out_data, input out_count, input last,
                   input stream_end, input total_out, input total_in, output ready);

endinterface

@@ design/lz_window_decompressor.sv @@
// channel    dir   payload                                                word
// req_chan   in    in_byte                                                one compressed byte
// rsp_chan   out   out_data, out_count, last, stream_end, total_out/in    up to LANES bytes
//
// Header, offset, literal and length bytes are each accepted in S_IDLE.
// A copy of L bytes goes through the history RAM byte by byte (S_READ, then S_WRITE back)
// plus an S_EMIT step per result word; the registered RAM read sets this pace.
// The history valid bits clear at reset, so no clearing pass: ready right after reset.
// A stalled result register holds req_chan off in idle and holds a copy at its next emit.
module lz_window_decompressor #(
   parameter int LANES      = 4,
   parameter int COUNT_BITS = 24
) (
   input  logic           clock,
   input  logic           reset,
   lzwd_req_if.sink       req_chan,
   lzwd_rsp_if.source     rsp_chan
);
   import lzwd_pkg::*;

   localparam int LC_W = $clog2(LANES + 1);

   typedef enum logic [1:0] {PH_HEADER, PH_LITERAL, PH_LENGTH} phase_type;
   typedef enum logic [1:0] {S_IDLE, S_READ, S_WRITE, S_EMIT} state_type;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      sat_inc = (v == '1) ? v : v + 1'b1;
   endfunction

   state_type                 state_ff, state_in;
   phase_type                 phase_ff, phase_in;
   logic [HIST_AW-1:0]        wp_ff, wp_in;
   logic [BYTE_W-1:0]         lit_left_ff, lit_left_in;
   logic [HIST_AW-1:0]        copy_off_ff, copy_off_in;
   logic [BYTE_W-1:0]         copy_left_ff, copy_left_in;
   logic [LANES*BYTE_W-1:0]   lane_buf_ff, lane_buf_in;
   logic [LC_W-1:0]           lane_cnt_ff, lane_cnt_in;
   logic [COUNT_BITS-1:0]     produced_ff, produced_in;
   logic [COUNT_BITS-1:0]     consumed_ff, consumed_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]         rsp_data_ff, rsp_data_in;
   logic [OCNT_W-1:0]         rsp_count_ff, rsp_count_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic                      rsp_end_ff, rsp_end_in;
   logic [TOTAL_W-1:0]        rsp_tout_ff, rsp_tout_in;
   logic [TOTAL_W-1:0]        rsp_tin_ff, rsp_tin_in;

   // history RAM
   logic [BYTE_W-1:0]         hist_mem [HIST_DEPTH];
   logic [HIST_DEPTH-1:0]     hist_vld_ff;
   logic                      mem_we;
   logic [HIST_AW-1:0]        mem_waddr;
   logic [BYTE_W-1:0]         mem_wdata;
   logic [HIST_AW-1:0]        mem_raddr;
   logic [BYTE_W-1:0]         rd_data_ff;
   logic                      rd_vld_ff;
   logic [BYTE_W-1:0]         copy_byte;

   logic                      rsp_free;
   logic                      req_accept;

   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && rsp_free;
   assign req_accept = req_chan.valid && req_chan.ready;

   assign mem_raddr = wp_ff + copy_off_ff;
   assign copy_byte = rd_vld_ff ? rd_data_ff : '0;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= hist_mem[mem_raddr];
   end

   // never-written entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_vld_ff <= '0;
         rd_vld_ff   <= 1'b0;
      end else begin
         if (mem_we) begin
            hist_vld_ff[mem_waddr] <= 1'b1;
         end
         rd_vld_ff <= hist_vld_ff[mem_raddr];
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      wp_in        = wp_ff;
      lit_left_in  = lit_left_ff;
      copy_off_in  = copy_off_ff;
      copy_left_in = copy_left_ff;
      lane_buf_in  = lane_buf_ff;
      lane_cnt_in  = lane_cnt_ff;
      produced_in  = produced_ff;
      consumed_in  = consumed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_tout_in  = rsp_tout_ff;
      rsp_tin_in   = rsp_tin_ff;
      mem_we       = 1'b0;
      mem_waddr    = wp_ff;
      mem_wdata    = copy_byte;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               consumed_in = sat_inc(consumed_ff);
               case (phase_ff)
                  PH_LITERAL: begin
                     mem_we       = 1'b1;
                     mem_wdata    = req_chan.in_byte;
                     wp_in        = wp_ff + 1'b1;
                     produced_in  = sat_inc(produced_ff);
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = DATA_W'(req_chan.in_byte);
                     rsp_count_in = OCNT_W'(1);
                     rsp_last_in  = 1'b1;
                     rsp_end_in   = 1'b0;
                     rsp_tout_in  = '0;
                     rsp_tin_in   = '0;
                     lit_left_in  = lit_left_ff - 1'b1;
                     if (lit_left_ff == BYTE_W'(1)) begin
                        phase_in = PH_HEADER;
                     end
                  end
                  PH_LENGTH: begin
                     phase_in = PH_HEADER;
                     if (req_chan.in_byte == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '0;
                        rsp_count_in = '0;
                        rsp_last_in  = 1'b1;
                        rsp_end_in   = 1'b1;
                        rsp_tout_in  = TOTAL_W'(produced_ff);
                        rsp_tin_in   = TOTAL_W'(sat_inc(consumed_ff));
                        produced_in  = '0;
                        consumed_in  = '0;
                     end else begin
                        copy_left_in = req_chan.in_byte;
                        lane_cnt_in  = '0;
                        lane_buf_in  = '0;
                        state_in     = S_READ;
                     end
                  end
                  default: begin
                     if (req_chan.in_byte < LIT_LIMIT) begin
                        lit_left_in = req_chan.in_byte + 1'b1;
                        phase_in    = PH_LITERAL;
                     end else begin
                        copy_off_in = req_chan.in_byte[HIST_AW-1:0];
                        phase_in    = PH_LENGTH;
                     end
                  end
               endcase
            end
         end
         S_READ: begin
            state_in = S_WRITE;
         end
         S_WRITE: begin
            // write lands before the next read, so overlapping copies see it
            mem_we       = 1'b1;
            wp_in        = wp_ff + 1'b1;
            produced_in  = sat_inc(produced_ff);
            for (int i = 0; i < LANES; i++) begin
               if (lane_cnt_ff == LC_W'(i)) begin
                  lane_buf_in[i*BYTE_W +: BYTE_W] = copy_byte;
               end
            end
            lane_cnt_in  = lane_cnt_ff + 1'b1;
            copy_left_in = copy_left_ff - 1'b1;
            if ((lane_cnt_ff + 1'b1 == LC_W'(LANES)) || (copy_left_ff == BYTE_W'(1))) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_READ;
            end
         end
         S_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = DATA_W'(lane_buf_ff);
               rsp_count_in = OCNT_W'(lane_cnt_ff);
               rsp_last_in  = (copy_left_ff == '0);
               rsp_end_in   = 1'b0;
               rsp_tout_in  = '0;
               rsp_tin_in   = '0;
               lane_buf_in  = '0;
               lane_cnt_in  = '0;
               state_in     = (copy_left_ff == '0) ? S_IDLE : S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_HEADER;
         wp_ff        <= '0;
         lit_left_ff  <= '0;
         copy_off_ff  <= '0;
         copy_left_ff <= '0;
         lane_cnt_ff  <= '0;
         produced_ff  <= '0;
         consumed_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         wp_ff        <= wp_in;
         lit_left_ff  <= lit_left_in;
         copy_off_ff  <= copy_off_in;
         copy_left_ff <= copy_left_in;
         lane_cnt_ff  <= lane_cnt_in;
         produced_ff  <= produced_in;
         consumed_ff  <= consumed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lane_buf_ff  <= lane_buf_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_tout_ff  <= rsp_tout_in;
      rsp_tin_ff   <= rsp_tin_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_data   = rsp_data_ff;
   assign rsp_chan.out_count  = rsp_count_ff;
   assign rsp_chan.last       = rsp_last_ff;
   assign rsp_chan.stream_end = rsp_end_ff;
   assign rsp_chan.total_out  = rsp_tout_ff;
   assign rsp_chan.total_in   = rsp_tin_ff;

   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WRITE |-> $past(state_ff) == S_READ)
      else $error("history write without a read the cycle before");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> lane_cnt_ff != '0)
      else $error("emitting an empty word");

   a_copy_phase: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> phase_ff == PH_HEADER)
      else $error("copy running outside header phase");

   a_copy_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ || state_ff == S_WRITE) |-> copy_left_ff != '0)
      else $error("copy step with nothing left");

endmodule
